### rtl/rsi_pkg.sv
`timescale 1ns / 1ps
package rsi_pkg;
	localparam int PRICE_BITS_DEF = 32;
	localparam int AVG_EXTRA_DEF = 16;
	localparam logic [7:0] PERIOD_RESET = 8'd14;
	localparam logic [7:0] WARM_DONE = 8'd255;
	localparam int RSI_BITS = 23;
	localparam logic [RSI_BITS-1:0] RSI_SCALE = 23'd6553600;
	localparam int QDEPTH = 2;
endpackage

### rtl/rsi_wilder_indicator.sv
`timescale 1ns / 1ps
// channel   dir  fields (tdata low bit up)             handshake
// s_axis    in   close_price[31:0]; tuser=series_start  tvalid/tready
// m_axis    out  rsi_value[22:0]; tuser=rsi_valid        tvalid/tready
// cfg       in   period_days                            cfg_we
// Smoothing or ending warm-up runs on the shared bit-serial divider (three 72-step divisions,
// one quotient bit a cycle); two divisions when the average loss is zero, and none for a
// first price or a warm-up step.
// Reset clears run state and sets the period to 14.
// A two-entry queue lets prices be taken while the back end divides; a waiting result
// holds the back end.
module rsi_wilder_indicator import rsi_pkg::*; #(
	parameter int PRICE_BITS = PRICE_BITS_DEF,
	parameter int AVG_EXTRA = AVG_EXTRA_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [7:0]            cfg_wdata,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [((PRICE_BITS+7)/8)*8-1:0] s_axis_tdata, // close_price
	input  logic                  s_axis_tuser,  // series_start
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [23:0]           m_axis_tdata,  // rsi_value
	output logic                  m_axis_tuser   // rsi_valid
);
	logic [7:0]          period_q;
	logic                q_valid, q_ready, q_first;
	logic [PRICE_BITS:0] q_delta;
	logic [RSI_BITS-1:0] rsi;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) period_q <= PERIOD_RESET;
		else if (cfg_we) period_q <= cfg_wdata;
	end

	rsi_front #(.PRICE_BITS(PRICE_BITS)) u_front (
		.clk, .arst_n, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.price(s_axis_tdata[PRICE_BITS-1:0]), .start(s_axis_tuser),
		.q_valid, .q_ready, .q_delta, .q_first);

	rsi_back #(.PRICE_BITS(PRICE_BITS), .AVG_EXTRA(AVG_EXTRA)) u_back (
		.clk, .arst_n, .period(period_q), .q_valid, .q_ready, .q_delta, .q_first,
		.o_valid(m_axis_tvalid), .o_ready(m_axis_tready), .o_rsi(rsi), .o_ok(m_axis_tuser));

	assign m_axis_tdata = {1'b0, rsi};
endmodule

### rtl/rsi_front.sv
`timescale 1ns / 1ps
module rsi_front import rsi_pkg::*; #(
	parameter int PRICE_BITS = PRICE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [PRICE_BITS-1:0] price,
	input  logic                  start,
	output logic                  q_valid,
	input  logic                  q_ready,
	output logic [PRICE_BITS:0]   q_delta,
	output logic                  q_first
);
	// classifies each price as first / gain / loss; bit PRICE_BITS = gain flag
	logic [PRICE_BITS-1:0] prev_q;
	logic                  have_q;
	logic [PRICE_BITS:0]   dq_q [QDEPTH];
	logic                  fq_q [QDEPTH];
	logic [1:0]            cnt_q;
	logic                  rd_q, wr_q;
	logic                  push, pop, gain;
	logic [PRICE_BITS-1:0] mag;

	assign in_ready = (cnt_q != 2'(QDEPTH));
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign pop = q_valid && q_ready;
	assign q_delta = dq_q[rd_q];
	assign q_first = fq_q[rd_q];
	assign gain = price > prev_q;
	assign mag = gain ? price - prev_q : prev_q - price;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			have_q <= 1'b0;
			cnt_q <= '0;
			rd_q <= 1'b0;
			wr_q <= 1'b0;
		end else begin
			if (push) begin
				prev_q <= price;
				have_q <= 1'b1;
				wr_q <= ~wr_q;
			end
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			dq_q[wr_q] <= {gain, mag};
			fq_q[wr_q] <= start || !have_q;
		end
	end
endmodule

### rtl/rsi_back.sv
`timescale 1ns / 1ps
module rsi_back import rsi_pkg::*; #(
	parameter int PRICE_BITS = PRICE_BITS_DEF,
	parameter int AVG_EXTRA = AVG_EXTRA_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [7:0]            period,
	input  logic                  q_valid,
	output logic                  q_ready,
	input  logic [PRICE_BITS:0]   q_delta,
	input  logic                  q_first,
	output logic                  o_valid,
	input  logic                  o_ready,
	output logic [RSI_BITS-1:0]   o_rsi,
	output logic                  o_ok
);
	localparam int AW = PRICE_BITS + AVG_EXTRA;
	localparam int NW = AW + 1;          // divisor width, fits the sum of averages
	localparam int RW = AW + 1 + RSI_BITS; // dividend for rsi
	localparam int DW = (RW > NW) ? RW : NW;
	localparam int CW = $clog2(DW + 1);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001, S_DG = 7'b0000010, S_DL = 7'b0000100,
		S_MUL = 7'b0001000, S_DR = 7'b0010000, S_FIN = 7'b0100000,
		S_OUT = 7'b1000000
	} st_t;

	st_t st_q;
	logic [7:0]          seen_q;
	logic [AW-1:0]       g_q, l_q;
	logic [AW-1:0]       xg_q, xl_q;
	logic                warm_q;
	logic [7:0]          n;
	// shared restoring divider
	logic [DW-1:0]       num_q, quo_q;
	logic [NW:0]         rem_q;
	logic [NW-1:0]       den_q;
	logic [CW-1:0]       bit_q;
	logic                busy_q;
	logic                done_q;
	logic [NW:0]         rtry;
	logic                sub_neg_q;
	logic [RSI_BITS-1:0] rsi_q;
	logic                ok_q;
	logic [AW-1:0]       mag_sc;
	logic [AW:0]         sumg, suml;
	logic [AW-1:0]       amax;
	logic [RW-1:0]       prod;

	assign n = (period == 8'd0) ? 8'd1 : period;
	assign amax = '1;
	assign q_ready = (st_q == S_IDLE) && !o_valid;
	assign mag_sc = (q_delta[PRICE_BITS-1:0] > PRICE_BITS'(amax >> AVG_EXTRA)) ? amax
		: (AW'(q_delta[PRICE_BITS-1:0]) << AVG_EXTRA);
	assign sumg = {1'b0, g_q} + {1'b0, (q_delta[PRICE_BITS] ? mag_sc : '0)};
	assign suml = {1'b0, l_q} + {1'b0, (q_delta[PRICE_BITS] ? '0 : mag_sc)};
	assign rtry = {rem_q[NW-1:0], num_q[DW-1]} - {1'b0, den_q};
	assign o_rsi = rsi_q;
	assign o_ok = ok_q;

	// control FSM and the division of num by den, result in quo_q, remainder in rem_q
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			seen_q <= '0;
			g_q <= '0;
			l_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q <= '0;
			o_valid <= 1'b0;
			warm_q <= 1'b0;
		end else begin
			if (o_valid && o_ready) o_valid <= 1'b0;
			if (busy_q) begin
				num_q <= num_q << 1;
				if (!rtry[NW]) begin
					rem_q <= rtry;
					quo_q <= {quo_q[DW-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[NW-1:0], num_q[DW-1]};
					quo_q <= {quo_q[DW-2:0], 1'b0};
				end
				bit_q <= bit_q - 1'b1;
				if (bit_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
			unique case (st_q)
				S_IDLE: if (q_valid && q_ready) begin
					if (q_first) begin
						seen_q <= '0;
						g_q <= '0;
						l_q <= '0;
						rsi_q <= '0;
						ok_q <= 1'b0;
						st_q <= S_OUT;
					end else if (seen_q != WARM_DONE) begin
						g_q <= sumg[AW] ? amax : sumg[AW-1:0];
						l_q <= suml[AW] ? amax : suml[AW-1:0];
						if (seen_q + 8'd1 >= n) begin
							warm_q <= 1'b1;
							seen_q <= WARM_DONE;
							xg_q <= '0;
							xl_q <= '0;
							st_q <= S_DG;
						end else begin
							seen_q <= seen_q + 8'd1;
							rsi_q <= '0;
							ok_q <= 1'b0;
							st_q <= S_OUT;
						end
					end else begin
						warm_q <= 1'b0;
						xg_q <= q_delta[PRICE_BITS] ? mag_sc : '0;
						xl_q <= q_delta[PRICE_BITS] ? '0 : mag_sc;
						st_q <= S_DG;
					end
					sub_neg_q <= 1'b0;
					busy_q <= 1'b0;
				end
				S_DG, S_DL: begin
					if (done_q) begin
						// division finished: apply
						done_q <= 1'b0;
						if (st_q == S_DG) begin
							if (warm_q) g_q <= AW'(quo_q);
							else if (!sub_neg_q) g_q <= g_q + AW'(quo_q);
							else g_q <= g_q - AW'(quo_q) - AW'(rem_q != '0);
							st_q <= S_DL;
						end else begin
							if (warm_q) l_q <= AW'(quo_q);
							else if (!sub_neg_q) l_q <= l_q + AW'(quo_q);
							else l_q <= l_q - AW'(quo_q) - AW'(rem_q != '0);
							st_q <= S_MUL;
						end
					end else if (!busy_q) begin
						// launch
						busy_q <= 1'b1;
						bit_q <= CW'(DW);
						rem_q <= '0;
						quo_q <= '0;
						den_q <= NW'(n);
						if (st_q == S_DG) begin
							sub_neg_q <= !warm_q && (xg_q < g_q);
							num_q <= warm_q ? DW'(g_q) :
								(xg_q >= g_q ? DW'(xg_q - g_q) : DW'(g_q - xg_q));
						end else begin
							sub_neg_q <= !warm_q && (xl_q < l_q);
							num_q <= warm_q ? DW'(l_q) :
								(xl_q >= l_q ? DW'(xl_q - l_q) : DW'(l_q - xl_q));
						end
					end
				end
				S_MUL: begin
					// times 100 in Q16: 2^22 + 2^21 + 2^18
					prod <= (RW'(g_q) << 22) + (RW'(g_q) << 21) + (RW'(g_q) << 18);
					st_q <= S_DR;
				end
				S_DR: begin
					if (l_q == '0) begin
						rsi_q <= '0;
						ok_q <= 1'b1;
						st_q <= S_OUT;
					end else if (done_q) begin
						done_q <= 1'b0;
						rsi_q <= RSI_BITS'(quo_q);
						ok_q <= 1'b1;
						st_q <= S_OUT;
					end else if (!busy_q) begin
						busy_q <= 1'b1;
						bit_q <= CW'(DW);
						rem_q <= '0;
						quo_q <= '0;
						num_q <= DW'(prod);
						den_q <= {1'b0, g_q} + {1'b0, l_q};
					end
				end
				S_OUT: begin
					o_valid <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) o_valid && !o_ready |=> o_valid)
		else $error("result dropped");
	assert property (@(posedge clk) disable iff (!arst_n) q_ready |-> !busy_q)
		else $error("accept while divider busy");
	assert property (@(posedge clk) disable iff (!arst_n) o_valid && o_ok |-> rsi_q <= RSI_SCALE)
		else $error("rsi out of range");
endmodule

### test/rsi_wilder_indicator_tb.sv
`timescale 1ns / 1ps
module rsi_wilder_indicator_tb;
	import rsi_pkg::*;

	typedef struct packed {
		logic [31:0] price;
		logic        start;
		logic        chk;     // typed-in expectation present
		logic [22:0] x_rsi;
		logic        x_valid;
	} row_t;

	typedef struct packed {
		logic [22:0] rsi;
		logic        valid;
	} rsi_res_t;

	localparam logic [47:0] AVG_ALL_ONES = 48'hFFFF_FFFF_FFFF;
	localparam int          STALL_LIMIT = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [7:0]  cfg_wdata = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tuser;

	rsi_wilder_indicator u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	always #10 clk = ~clk;

	// predictor state
	logic [7:0]  period;
	logic [31:0] last_close;
	logic        have_last;
	logic [7:0]  warm_count;
	logic [63:0] avg_gain, avg_loss;

	rsi_res_t    expected_rsi[$];
	int          errors = 0;
	int          stall_cycles = 0;
	bit          quiet = 1'b0;
	bit          sink_idle = 1'b0;

	function automatic logic [63:0] scale_move(logic [63:0] d);
		if (d > (AVG_ALL_ONES >> 16)) return AVG_ALL_ONES;
		return d << 16;
	endfunction

	function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
		if (a + b > AVG_ALL_ONES) return AVG_ALL_ONES;
		return a + b;
	endfunction

	function automatic logic [63:0] smooth(logic [63:0] avg, logic [63:0] x,
			logic [63:0] n);
		logic [63:0] d;
		if (x >= avg) return avg + (x - avg) / n;
		d = avg - x;
		return avg - (d / n + ((d % n) != 0 ? 64'd1 : 64'd0));
	endfunction

	function automatic rsi_res_t predict_rsi(logic [31:0] price, logic start);
		logic [63:0]  n, gain, loss;
		logic [127:0] num;
		rsi_res_t     r;
		n = (period == 0) ? 64'd1 : 64'(period);
		gain = 0;
		loss = 0;
		r = '0;
		if (start || !have_last) begin
			have_last = 1'b1;
			last_close = price;
			warm_count = 0;
			avg_gain = 0;
			avg_loss = 0;
			return r;
		end
		if (price > last_close) gain = scale_move(64'(price - last_close));
		else loss = scale_move(64'(last_close - price));
		last_close = price;
		if (warm_count != WARM_DONE) begin
			avg_gain = sat_sum(avg_gain, gain);
			avg_loss = sat_sum(avg_loss, loss);
			warm_count = warm_count + 8'd1;
			if (64'(warm_count) >= n) begin
				avg_gain = avg_gain / n;
				avg_loss = avg_loss / n;
				warm_count = WARM_DONE;
			end
		end else begin
			avg_gain = smooth(avg_gain, gain, n);
			avg_loss = smooth(avg_loss, loss, n);
		end
		if (warm_count == WARM_DONE) begin
			r.valid = 1'b1;
			if (avg_loss != 0) begin
				num = 128'(avg_gain) * 128'(RSI_SCALE);
				r.rsi = 23'(num / 128'(avg_gain + avg_loss));
			end
		end
		return r;
	endfunction

	task automatic write_period(logic [7:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		period = v;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (expected_rsi.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic send_price(logic [31:0] price, logic start);
		rsi_res_t r;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= price;
		s_axis_tuser <= start;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		r = predict_rsi(price, start);
		expected_rsi.push_back(r);
	endtask

	// sink stall bursts
	always @(posedge clk) begin
		if (quiet) m_axis_tready <= 1'b1;
		else if (!sink_idle && $urandom_range(0, 3) == 0) begin
			sink_idle <= 1'b1;
			m_axis_tready <= 1'b0;
			fork
				begin
					repeat ($urandom_range(1, 10)) @(posedge clk);
					sink_idle <= 1'b0;
				end
			join_none
		end else if (!sink_idle) m_axis_tready <= 1'b1;
	end

	always @(posedge clk) begin
		rsi_res_t x;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_rsi.size() == 0) begin
				$error("unexpected result rsi_value=%0d", m_axis_tdata[22:0]);
				errors++;
			end else begin
				x = expected_rsi.pop_front();
				if (m_axis_tdata[22:0] !== x.rsi) begin
					$error("rsi_value exp %0d got %0d", x.rsi, m_axis_tdata[22:0]);
					errors++;
				end
				if (m_axis_tuser !== x.valid) begin
					$error("rsi_valid exp %0d got %0d", x.valid, m_axis_tuser);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	row_t directed[] = '{
		'{32'h0000_0000, 1'b1, 1'b1, 23'd0, 1'b0},
		'{32'hFFFF_FFFF, 1'b0, 1'b1, 23'd0, 1'b1},       // huge gain, no loss
		'{32'h0000_0000, 1'b0, 1'b0, 23'd0, 1'b0},
		'{32'h0000_0000, 1'b0, 1'b0, 23'd0, 1'b0},       // zero change -> loss side
		'{32'h0001_0000, 1'b1, 1'b1, 23'd0, 1'b0},
		'{32'h0001_0000, 1'b0, 1'b1, 23'd0, 1'b1},       // flat: loss 0 -> rsi 0
		'{32'h0000_8000, 1'b0, 1'b1, 23'd0, 1'b1},       // pure loss
		'{32'h0002_0000, 1'b0, 1'b0, 23'd0, 1'b0},
		'{32'hFFFF_FFFF, 1'b0, 1'b0, 23'd0, 1'b0},
		'{32'h0000_0001, 1'b0, 1'b0, 23'd0, 1'b0},
		'{32'h0000_0001, 1'b1, 1'b1, 23'd0, 1'b0},
		'{32'h8000_0000, 1'b0, 1'b0, 23'd0, 1'b0},
		'{32'h7FFF_FFFF, 1'b0, 1'b0, 23'd0, 1'b0}
	};

	initial begin
		rsi_res_t r;
		logic [31:0] p;
		int len;
		period = PERIOD_RESET;
		last_close = 0;
		have_last = 0;
		warm_count = 0;
		avg_gain = 0;
		avg_loss = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// short warm-up at period 1 for the typed rows
		write_period(8'd1);
		foreach (directed[i]) begin
			send_price(directed[i].price, directed[i].start);
			if (directed[i].chk) begin
				r = expected_rsi[$];
				if (r.rsi !== directed[i].x_rsi || r.valid !== directed[i].x_valid) begin
					$error("table row %0d disagrees with predictor", i);
					errors++;
				end
			end
		end
		drain();

		// period zero, max, then lowered in warm-up
		write_period(8'd0);
		send_price(32'd100, 1'b1);
		send_price(32'd200, 1'b0);
		drain();
		write_period(8'd255);
		send_price(32'd5, 1'b1);
		repeat (3) send_price($urandom, 1'b0);
		drain();
		write_period(8'd2);
		send_price($urandom, 1'b0);
		send_price($urandom, 1'b0);
		drain();

		// random series, several periods
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: write_period(8'd14);
				1: write_period(8'd2);
				2: write_period(8'd255);
				3: write_period(8'($urandom_range(2, 30)));
				4: write_period(8'd3);
				default: write_period(PERIOD_RESET);
			endcase
			if (ph == 5) quiet = 1'b1;
			for (int k = 0; k < 190; ) begin
				len = (ph == 2) ? 300 : $urandom_range(5, 60);
				p = $urandom;
				send_price(p, 1'b1);
				k++;
				for (int j = 0; j < len && k < 190; j++, k++) begin
					case ($urandom_range(0, 9))
						0: p = $urandom;
						1: p = p;
						2: p = 32'hFFFF_FFFF;
						3: p = 32'h0;
						default: p = p + 32'($urandom_range(0, 20000)) - 32'd10000;
					endcase
					send_price(p, ($urandom_range(0, 200) == 0));
				end
			end
			if (ph == 1) begin
				// wait for every result before resuming
				s_axis_tvalid <= 1'b0;
				while (expected_rsi.size() != 0) @(posedge clk);
				send_price($urandom, 1'b0);
			end
			drain();
		end

		if (errors == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end
endmodule
